// ===== src/msr_pkg.sv =====
// Shared constants, types and helpers of the marker span rasterizer.
package msr_pkg;

  localparam int MAX_EXTENT = 12;

  // Marker diameter in 1/16 px, clamped range
  localparam int D_MIN = 96;
  localparam int D_MAX = MAX_EXTENT * 16;
  localparam int DW    = $clog2(D_MAX + 1);

  // Line heights at or above this clamp the diameter to D_MAX
  localparam int LH_LIM = (20 * (D_MAX + 1) + 10) / 11;
  localparam int LW     = $clog2(LH_LIM);
  localparam int XW     = LW + 4;

  // Reciprocals: x / 20 = (x * 3277) >> 16, x / 5 = (x * 205) >> 10 over the used ranges
  localparam int RECIP20 = 3277;
  localparam int RECIP5  = 205;

  // Ring thickness clamp, 1/32 px
  localparam int T_MIN = 32;
  localparam int T_MAX = 80;
  localparam int TW    = 7;

  localparam int RW  = $clog2(MAX_EXTENT + 1);
  localparam int DYW = DW + 3;
  localparam int SQW = 2 * DW;
  localparam int RTW = DW;
  localparam int CW  = 19;

  localparam logic [31:0] PLAIN_COLOR_RST       = 32'hFF0000FF;
  localparam logic [31:0] UNVERIFIED_COLOR_RST  = 32'h808080FF;
  localparam logic [31:0] CONDITIONAL_COLOR_RST = 32'hFFA500FF;
  localparam logic [9:0]  MARKER_INSET_RST      = 10'd48;

  localparam logic [1:0] KIND_CONDITIONAL = 2'd1;
  localparam logic [1:0] KIND_DIAMOND     = 2'd2;

  typedef enum logic [1:0] {
    REG_PLAIN_COLOR,
    REG_UNVERIFIED_COLOR,
    REG_CONDITIONAL_COLOR,
    REG_MARKER_INSET
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIZE,
    S_GEOM,
    S_ISQ,
    S_ROW,
    S_OSTART,
    S_OWAIT,
    S_ISTART,
    S_IWAIT,
    S_EMIT_A,
    S_EMIT_B,
    S_NEXT,
    S_FIN
  } msr_state_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] row;
    logic [11:0]        length;
  } span_t;

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = CW'(32767);
    lo = -CW'(32768);
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== src/msr_channels.sv =====
// Handshake channels of the marker span rasterizer: request, span result and register write.
interface msr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gutter_left;
  logic signed [15:0] row_top;
  logic signed [15:0] gutter_span;
  logic signed [15:0] row_height;
  logic               is_verified;
  logic [1:0]         marker_kind;
  logic               is_enabled;

  modport source (
    output valid, gutter_left, row_top, gutter_span, row_height,
           is_verified, marker_kind, is_enabled,
    input  ready
  );
  modport sink (
    input  valid, gutter_left, row_top, gutter_span, row_height,
           is_verified, marker_kind, is_enabled,
    output ready
  );
endinterface

interface msr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] span_left;
  logic signed [15:0] span_row;
  logic [11:0]        span_length;
  logic [31:0]        tint;
  logic               span_valid;
  logic               last_span;

  modport source (
    output valid, span_left, span_row, span_length, tint, span_valid, last_span,
    input  ready
  );
  modport sink (
    input  valid, span_left, span_row, span_length, tint, span_valid, last_span,
    output ready
  );
endinterface

interface msr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/msr_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module msr_isqrt import msr_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [SQW-1:0] operand,
  output logic           busy,
  output logic [RTW-1:0] root
);

  localparam int CNW = $clog2(RTW + 1);

  logic           run_r;
  logic [CNW-1:0] cnt_r;
  logic [SQW-1:0] val_r;
  logic [RTW:0]   rem_r;
  logic [RTW-1:0] root_r;

  logic [RTW+2:0] remt;
  logic [RTW+2:0] trial;
  logic [RTW+2:0] diff;
  logic           ge;

  assign remt  = {rem_r, val_r[SQW-1 -: 2]};
  assign trial = (RTW+3)'({root_r, 2'b01});
  assign ge    = remt >= trial;
  assign diff  = remt - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CNW'(RTW);
    end else if (run_r) begin
      cnt_r <= cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      val_r  <= val_r << 2;
      rem_r  <= ge ? diff[RTW:0] : remt[RTW:0];
      root_r <= {root_r[RTW-2:0], ge};
    end
  end

  assign busy = run_r;
  assign root = root_r;

endmodule

// ===== src/marker_shape_span_rasterizer_unit.sv =====
// Top level of the marker span rasterizer: sequencer, geometry datapath and output stage.
//
// in_bus carries one marker request per beat; out_bus returns its spans, one beat per
// span, last_span set on the final beat. A request that is suppressed (gutter width or
// line height not positive) or whose shape is empty yields a single beat with
// span_valid clear. cfg_bus writes the tint and inset registers; it is always ready and
// should only be used while no request is in flight.
// A request is taken only while the sequencer is idle. Setup passes the size, geometry and
// inner-square states after the accepting one; then each shape row is skipped when it lies
// outside the shape, or else the 8-step square-root unit computes its outer and, for a ring
// disc row, inner half width in turn; diamond rows skip the square-root unit. A worst-case
// request at the default extent has 12 rows.
// Each span is held in a one-entry pending register so the last flag can be set once
// the end is known; beats leave through an output register, so a stalled receiver only
// holds span production when both are full, and the final beat while the output is full.
// Reset returns the sequencer to idle, empties the output stage and reloads the register reset values.
module marker_shape_span_rasterizer_unit import msr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  msr_in_if.sink   in_bus,
  msr_out_if.source out_bus,
  msr_cfg_if.sink  cfg_bus
);

  msr_state_t state_r, state_nxt;

  // configuration
  logic [31:0] plain_color_r;
  logic [31:0] unverified_color_r;
  logic [31:0] conditional_color_r;
  logic [9:0]  marker_inset_r;

  // per-request state
  logic signed [15:0] gx_r, ry_r, lh_r;
  logic               enabled_r, diamond_r;
  logic [31:0]        tint_r;
  logic [DW-1:0]      d_r, ir_r, ady_r, outer_r, inner_r;
  logic [TW-1:0]      t_r;
  logic [RW-1:0]      rows_r, i_r;
  logic signed [CW-1:0] by_r, cx_r;
  logic [SQW-1:0]     rsq_r, irsq_r, asq_r;

  // output staging
  span_t       pend_r;
  logic        pend_v_r;
  span_t       out_span_r;
  logic [31:0] out_tint_r;
  logic        out_sv_r, out_last_r, out_valid_r;

  // square root unit
  logic           sq_start, sq_busy;
  logic [SQW-1:0] sq_operand;
  logic [RTW-1:0] sq_root;

  msr_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .operand (sq_operand),
    .busy    (sq_busy),
    .root    (sq_root)
  );

  // ---------------- request intake ----------------
  logic        suppress;
  logic [9:0]  a3;
  logic [17:0] a_prod;
  logic [31:0] tint_w;

  assign suppress = (in_bus.gutter_span <= 16'sd0) || (in_bus.row_height <= 16'sd0);
  assign a3       = 10'(conditional_color_r[7:0]) * 10'd3;
  assign a_prod   = 18'(a3) * 18'(RECIP5);

  always_comb begin
    if (in_bus.marker_kind == KIND_CONDITIONAL) begin
      tint_w = in_bus.is_verified ? conditional_color_r
                                  : {conditional_color_r[31:8], a_prod[17:10]};
    end else begin
      tint_w = in_bus.is_verified ? plain_color_r : unverified_color_r;
    end
  end

  // ---------------- diameter ----------------
  logic              big_w;
  logic [XW-1:0]     x11_w, q20_w;
  logic [XW+15:0]    q20_prod;
  logic [DW-1:0]     d_w;

  assign big_w    = $unsigned(lh_r) >= 16'(LH_LIM);
  assign x11_w    = XW'(lh_r[LW-1:0]) * XW'(11);
  assign q20_prod = (XW+16)'(x11_w) * (XW+16)'(RECIP20);
  assign q20_w    = q20_prod[XW+15:16];

  always_comb begin
    if (big_w) begin
      d_w = DW'(D_MAX);
    end else if (q20_w < XW'(D_MIN)) begin
      d_w = DW'(D_MIN);
    end else begin
      d_w = DW'(q20_w);
    end
  end

  // ---------------- box geometry ----------------
  logic [DW+3:0]        d9_w;
  logic [DW+15:0]       t_prod;
  logic [DW-1:0]        tq_w;
  logic [TW-1:0]        t_w;
  logic [DW:0]          d15_w;
  logic signed [16:0]   slk_w;
  logic signed [CW-1:0] by_w, bx_w, cx_w;
  logic [DW-1:0]        ir_w;

  assign d9_w   = (DW+4)'(d_r) * (DW+4)'(9);
  assign t_prod = (DW+16)'(d9_w) * (DW+16)'(RECIP20);
  assign tq_w   = t_prod[DW+15:16];

  always_comb begin
    if (tq_w < DW'(T_MIN)) begin
      t_w = TW'(T_MIN);
    end else if (tq_w > DW'(T_MAX)) begin
      t_w = TW'(T_MAX);
    end else begin
      t_w = TW'(tq_w);
    end
  end

  assign d15_w = (DW+1)'(d_r) + (DW+1)'(15);
  assign slk_w = 17'(lh_r) - $signed(17'(d_r));
  assign by_w  = CW'(ry_r) + ((slk_w > 17'sd0) ? CW'(slk_w >>> 1) : CW'(0));
  assign bx_w  = CW'(gx_r) + $signed(CW'(marker_inset_r));
  assign cx_w  = (bx_w <<< 1) + $signed(CW'(d_r));
  assign ir_w  = d_r - DW'(t_r);

  // ---------------- row geometry ----------------
  logic signed [DYW-1:0] dy_w;
  logic [DYW-1:0]        ady_w;
  logic                  row_out_w;
  logic [DW-1:0]         sq_in;
  logic [SQW-1:0]        sq_out;
  logic [DW-1:0]         outer_w, inner_w;

  assign dy_w      = $signed(DYW'({i_r, 5'b0})) + $signed(DYW'(16)) - $signed(DYW'(d_r));
  assign ady_w     = dy_w[DYW-1] ? DYW'(-dy_w) : DYW'(dy_w);
  assign row_out_w = ady_w > DYW'(d_r);
  assign outer_w   = diamond_r ? (d_r - ady_r) : DW'(sq_root);
  assign inner_w   = diamond_r ? (ir_r - ady_r) : DW'(sq_root);

  always_comb begin
    case (state_r)
      S_GEOM:  sq_in = d_r;
      S_ISQ:   sq_in = ir_w;
      default: sq_in = ady_w[DW-1:0];
    endcase
  end

  assign sq_out = SQW'(sq_in) * SQW'(sq_in);

  // ---------------- span assembly ----------------
  logic signed [CW-1:0] row_w, left_a_w, left_b_w;
  logic [DW-1:0]        ring_len_w;
  span_t                new_span;

  assign row_w      = by_r + $signed(CW'({i_r, 4'b0}));
  assign left_a_w   = (cx_r - $signed(CW'(outer_r))) >>> 1;
  assign left_b_w   = (cx_r + $signed(CW'(inner_r))) >>> 1;
  assign ring_len_w = (outer_r - inner_r) >> 1;

  always_comb begin
    new_span.row = sat16(row_w);
    if (state_r == S_EMIT_B) begin
      new_span.left   = sat16(left_b_w);
      new_span.length = 12'(ring_len_w);
    end else begin
      new_span.left   = sat16(left_a_w);
      new_span.length = (inner_r == '0) ? 12'(outer_r) : 12'(ring_len_w);
    end
  end

  // ---------------- sequencer ----------------
  logic  can_push, prod_ok, produce;
  logic  push, push_valid, push_last;
  span_t push_span;

  assign can_push = !out_valid_r || out_bus.ready;
  assign prod_ok  = !pend_v_r || can_push;

  always_comb begin
    state_nxt  = state_r;
    sq_start   = 1'b0;
    sq_operand = rsq_r - asq_r;
    produce    = 1'b0;
    push       = 1'b0;
    push_valid = 1'b0;
    push_last  = 1'b0;
    push_span  = pend_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          state_nxt = suppress ? S_FIN : S_SIZE;
        end
      end
      S_SIZE: state_nxt = S_GEOM;
      S_GEOM: state_nxt = S_ISQ;
      S_ISQ:  state_nxt = S_ROW;
      S_ROW: begin
        if (i_r == rows_r) begin
          state_nxt = S_FIN;
        end else if (row_out_w) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_OSTART;
        end
      end
      S_OSTART: begin
        sq_start  = !diamond_r;
        state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        if (!sq_busy) begin
          if (outer_w == '0) begin
            state_nxt = S_NEXT;
          end else if (enabled_r || (ady_r > ir_r)) begin
            state_nxt = S_EMIT_A;
          end else begin
            state_nxt = S_ISTART;
          end
        end
      end
      S_ISTART: begin
        sq_start   = !diamond_r;
        sq_operand = irsq_r - asq_r;
        state_nxt  = S_IWAIT;
      end
      S_IWAIT: begin
        if (!sq_busy) begin
          state_nxt = S_EMIT_A;
        end
      end
      S_EMIT_A: begin
        produce = 1'b1;
        if (prod_ok) begin
          state_nxt = (inner_r == '0) ? S_NEXT : S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        produce = 1'b1;
        if (prod_ok) begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: state_nxt = S_ROW;
      S_FIN: begin
        if (can_push) begin
          push       = 1'b1;
          push_valid = pend_v_r;
          push_last  = 1'b1;
          push_span  = pend_v_r ? pend_r : '0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a new span displaces the pending one to the output register
    if (produce && prod_ok && pend_v_r) begin
      push       = 1'b1;
      push_valid = 1'b1;
      push_span  = pend_r;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      pend_v_r            <= 1'b0;
      out_valid_r         <= 1'b0;
      plain_color_r       <= PLAIN_COLOR_RST;
      unverified_color_r  <= UNVERIFIED_COLOR_RST;
      conditional_color_r <= CONDITIONAL_COLOR_RST;
      marker_inset_r      <= MARKER_INSET_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && can_push) begin
        pend_v_r <= 1'b0;
      end else if (produce && prod_ok) begin
        pend_v_r <= 1'b1;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_bus.valid) begin
        unique case (cfg_reg_t'(cfg_bus.index))
          REG_PLAIN_COLOR:       plain_color_r       <= cfg_bus.data;
          REG_UNVERIFIED_COLOR:  unverified_color_r  <= cfg_bus.data;
          REG_CONDITIONAL_COLOR: conditional_color_r <= cfg_bus.data;
          REG_MARKER_INSET:      marker_inset_r      <= cfg_bus.data[9:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_bus.valid) begin
      gx_r      <= in_bus.gutter_left;
      ry_r      <= in_bus.row_top;
      lh_r      <= in_bus.row_height;
      enabled_r <= in_bus.is_enabled;
      diamond_r <= in_bus.marker_kind == KIND_DIAMOND;
      tint_r    <= tint_w;
    end
    case (state_r)
      S_SIZE: d_r <= d_w;
      S_GEOM: begin
        t_r    <= t_w;
        rows_r <= RW'(d15_w[DW:4]);
        by_r   <= by_w;
        cx_r   <= cx_w;
        rsq_r  <= sq_out;
        i_r    <= '0;
      end
      S_ISQ: begin
        ir_r   <= ir_w;
        irsq_r <= sq_out;
      end
      S_ROW: begin
        ady_r <= ady_w[DW-1:0];
        asq_r <= sq_out;
      end
      S_OWAIT: begin
        outer_r <= outer_w;
        inner_r <= '0;
      end
      S_IWAIT: inner_r <= inner_w;
      S_NEXT:  i_r <= i_r + RW'(1);
      default: ;
    endcase
    if (produce && prod_ok) begin
      pend_r <= new_span;
    end
    if (push) begin
      out_span_r <= push_span;
      out_tint_r <= push_valid ? tint_r : 32'd0;
      out_sv_r   <= push_valid;
      out_last_r <= push_last;
    end
  end

  assign in_bus.ready        = (state_r == S_IDLE);
  assign cfg_bus.ready       = 1'b1;
  assign out_bus.valid       = out_valid_r;
  assign out_bus.span_left   = out_span_r.left;
  assign out_bus.span_row    = out_span_r.row;
  assign out_bus.span_length = out_span_r.length;
  assign out_bus.tint        = out_tint_r;
  assign out_bus.span_valid  = out_sv_r;
  assign out_bus.last_span   = out_last_r;

endmodule
